### hw/rtl/arrip_pkg.sv
// Shared constants for the adaptive RRIP replacement core.
package arrip_pkg;

   // Field widths fixed by the request and response formats.
   localparam int SET_W    = 11;
   localparam int WAY_W    = 4;
   localparam int CHANCE_W = 5;

   // Number of sets equals the reach of the set index, so no wrap is needed.
   localparam int SETS = 1 << SET_W;

   // Defaults for the top level parameters.
   localparam int DEF_NUM_WAYS  = 16;
   localparam int DEF_PHASE_LEN = 128;

   // Re-reference prediction values.
   localparam logic [1:0] RRPV_MAX  = 2'd3;
   localparam logic [1:0] RRPV_FAR  = 2'd2;
   localparam logic [1:0] RRPV_NEAR = 2'd0;

   // Operation codes.
   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

endpackage

### hw/rtl/adaptive_rrip_replacement_core.sv
// Adaptive RRIP replacement core: per-set 2-bit RRPV rows and insertion preference.
//
//   Channel    Ports                                              Direction
//   ---------  -------------------------------------------------  ---------
//   request    start, busy (out), req_op, req_set_index, req_way_index,  in
//              req_hit, req_chance
//   response   rsp_strobe, rsp_victim_way, rsp_prefers_lru        out
//
// In the cycle after a request is accepted, the set's row is read from the
// row memory, modified and written back, and the response is shown on the
// following cycle for exactly one cycle. The next request can be accepted in
// that same cycle, so requests do not overlap: each waits for the single
// read-modify-write of the row memory to finish.
// After reset the core sweeps the row memory once, one row a cycle, so busy
// stays high until all SETS (2048) rows are cleared; no request is taken before.
// The receiver cannot stall; each response is taken in the cycle it is shown.
module adaptive_rrip_replacement_core #(
   parameter int NUM_WAYS  = arrip_pkg::DEF_NUM_WAYS,
   parameter int PHASE_LEN = arrip_pkg::DEF_PHASE_LEN
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_op,
   input  logic [arrip_pkg::SET_W-1:0]    req_set_index,
   input  logic [arrip_pkg::WAY_W-1:0]    req_way_index,
   input  logic                          req_hit,
   input  logic [arrip_pkg::CHANCE_W-1:0] req_chance,
   output logic                          rsp_strobe,
   output logic [arrip_pkg::WAY_W-1:0]    rsp_victim_way,
   output logic                          rsp_prefers_lru
);

   // Width of the window counters; both stay below PHASE_LEN once stored.
   localparam int CW = $clog2(PHASE_LEN);
   // Width of a way number.
   localparam int VW = $clog2(NUM_WAYS);

   // One memory row holds everything the core keeps for one set.
   typedef struct packed {
      logic                     pref;
      logic [CW-1:0]            hits;
      logic [CW-1:0]            accs;
      logic [NUM_WAYS-1:0][1:0] rrpv;
   } row_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ACCESS
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [arrip_pkg::SET_W-1:0]    clr_idx_ff;
   logic [arrip_pkg::SET_W-1:0]    clr_idx_in;

   // Request held for the access cycle.
   logic                           op_ff;
   logic [arrip_pkg::SET_W-1:0]    set_ff;
   logic [arrip_pkg::WAY_W-1:0]    way_ff;
   logic                           hit_ff;
   logic [arrip_pkg::CHANCE_W-1:0] chance_ff;

   // Response registers.
   logic                           rsp_strobe_ff;
   logic                           rsp_strobe_in;
   logic [arrip_pkg::WAY_W-1:0]    rsp_victim_ff;
   logic [arrip_pkg::WAY_W-1:0]    rsp_victim_in;
   logic                           rsp_pref_ff;
   logic                           rsp_pref_in;

   // Row memory with a registered read.
   row_type                        row_mem [arrip_pkg::SETS];
   row_type                        rd_row_ff;
   row_type                        new_row;
   row_type                        reset_row;

   // Datapath of the access cycle.
   logic                           has3;
   logic                           has2;
   logic                           has1;
   logic [1:0]                     top;
   logic [1:0]                     age;
   logic [NUM_WAYS-1:0][1:0]       aged;
   logic [VW-1:0]                  victim;
   logic [CW:0]                    accs_inc;
   logic [CW:0]                    hits_inc;
   logic [CW+1:0]                  hits_dbl;
   logic                           window_end;
   logic                           pref_new;
   logic [1:0]                     ins_val;
   logic                           accept;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   always_comb begin
      reset_row      = '0;
      reset_row.pref = 1'b1;
      for (int w = 0; w < NUM_WAYS; w++) begin
         reset_row.rrpv[w] = arrip_pkg::RRPV_MAX;
      end
   end

   // Victim query: age the row just far enough that some way reaches the
   // maximum, then take the lowest such way.
   always_comb begin
      has3 = 1'b0;
      has2 = 1'b0;
      has1 = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
         if (rd_row_ff.rrpv[w] == 2'd3) has3 = 1'b1;
         if (rd_row_ff.rrpv[w] == 2'd2) has2 = 1'b1;
         if (rd_row_ff.rrpv[w] == 2'd1) has1 = 1'b1;
      end
      if (has3) begin
         top = 2'd3;
      end else if (has2) begin
         top = 2'd2;
      end else if (has1) begin
         top = 2'd1;
      end else begin
         top = 2'd0;
      end
      age = arrip_pkg::RRPV_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++) begin
         aged[w] = rd_row_ff.rrpv[w] + age;
      end
      victim = '0;
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
         if (aged[w] == arrip_pkg::RRPV_MAX) victim = VW'(w);
      end
   end

   // Update: count the access and the hit, close the window when it is full,
   // then insert or promote the addressed way.
   always_comb begin
      accs_inc   = {1'b0, rd_row_ff.accs} + (CW+1)'(1);
      hits_inc   = {1'b0, rd_row_ff.hits} + (CW+1)'(hit_ff);
      hits_dbl   = {hits_inc, 1'b0};
      window_end = (accs_inc >= (CW+1)'(PHASE_LEN));
      pref_new   = window_end ? (hits_dbl > (CW+2)'(PHASE_LEN)) : rd_row_ff.pref;
      if (hit_ff || pref_new) begin
         ins_val = arrip_pkg::RRPV_NEAR;
      end else if (chance_ff == '0) begin
         ins_val = arrip_pkg::RRPV_NEAR;
      end else begin
         ins_val = arrip_pkg::RRPV_FAR;
      end
   end

   always_comb begin
      new_row       = rd_row_ff;
      rsp_victim_in = '0;
      rsp_pref_in   = rd_row_ff.pref;
      if (op_ff == arrip_pkg::OP_QUERY) begin
         new_row.rrpv  = aged;
         rsp_victim_in = arrip_pkg::WAY_W'(victim);
      end else begin
         new_row.pref = pref_new;
         new_row.accs = window_end ? '0 : accs_inc[CW-1:0];
         new_row.hits = window_end ? '0 : hits_inc[CW-1:0];
         for (int w = 0; w < NUM_WAYS; w++) begin
            if (w == int'(way_ff)) new_row.rrpv[w] = ins_val;
         end
         rsp_pref_in = pref_new;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      rsp_strobe_in = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            clr_idx_in = clr_idx_ff + arrip_pkg::SET_W'(1);
            if (clr_idx_ff == arrip_pkg::SET_W'(arrip_pkg::SETS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) state_in = ST_ACCESS;
         end
         ST_ACCESS: begin
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_idx_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_idx_ff    <= clr_idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req_op;
         set_ff    <= req_set_index;
         way_ff    <= req_way_index;
         hit_ff    <= req_hit;
         chance_ff <= req_chance;
      end
      if (state_ff == ST_ACCESS) begin
         rsp_victim_ff <= rsp_victim_in;
         rsp_pref_ff   <= rsp_pref_in;
      end
   end

   // Row memory read port: the row of the accepted request is ready in the
   // access cycle. A write lands before the earliest following read.
   always_ff @(posedge clock) begin
      rd_row_ff <= row_mem[req_set_index];
   end

   // Row memory write port: the clearing sweep, then write-back of accesses.
   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         row_mem[clr_idx_ff] <= reset_row;
      end else if (state_ff == ST_ACCESS) begin
         row_mem[set_ff] <= new_row;
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_victim_way  = rsp_victim_ff;
   assign rsp_prefers_lru = rsp_pref_ff;

   // An accepted request is always answered with a response strobe.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("request accepted without a response two cycles later");

   // The core is busy in the cycle after it accepts a request.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("core not busy during the access cycle");

   // A response only follows a busy cycle and is shown while the core is free.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("response outside the access sequence");

endmodule
